[design/multi_channel_tachometer_turbine_speed_unit_assert.svh]
// ----------------------------------------------------------------------------
// tachometer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_TACHOMETER_TURBINE_SPEED_UNIT_ASSERT_SVH
`define MULTI_CHANNEL_TACHOMETER_TURBINE_SPEED_UNIT_ASSERT_SVH

// condition holds at every edge
`define MCT_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tachometer assertion failed");

// consequent holds at the edge after the antecedent
`define MCT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tachometer assertion failed");

`endif

[design/mctach_pkg.sv]
// ----------------------------------------------------------------------------
// mctach_pkg
// shared types, constants and helpers of the four channel tachometer
// ----------------------------------------------------------------------------
`default_nettype none

package mctach_pkg;

    localparam int NUM_CH     = 4;
    localparam int CNT_W      = 15;
    localparam int WIN_W      = 10;
    localparam int TEETH_W    = 8;
    localparam int GAIN_W     = 16;
    localparam int RPM_W      = 16;
    localparam int SEQ_W      = 16;
    localparam int NUM_W      = 31;
    localparam int DEN_W      = TEETH_W + WIN_W;
    localparam int OUT_DATA_W = 6 * RPM_W;
    localparam int IN_DATA_W  = 8;
    localparam int IDX_W      = 3;
    localparam int Q_FRAC     = 12;

    localparam logic [CNT_W-1:0]  COUNT_LIMIT = 15'd32767;
    localparam logic [15:0]       MS_PER_MIN  = 16'd60000;
    localparam logic [GAIN_W:0]   Q_ONE       = 17'd4096;

    // channel order inside the count vector
    localparam int CH_N2     = 0;
    localparam int CH_N3     = 1;
    localparam int CH_OUTPUT = 2;
    localparam int CH_ENGINE = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_TEETH_N2     = 3'd0,
        REG_TEETH_N3     = 3'd1,
        REG_TEETH_OUTPUT = 3'd2,
        REG_ENGINE_PPR   = 3'd3,
        REG_BLEND_GAIN   = 3'd4,
        REG_WINDOW_MS    = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [NUM_CH-1:0][TEETH_W-1:0] teeth;
        logic [GAIN_W-1:0]              gain;
        logic [WIN_W-1:0]               window;
    } cfg_t;

    typedef logic [NUM_CH-1:0][CNT_W-1:0] snap_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // a zero window behaves as a one tick window
    function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] w);
        eff_window = (w == '0) ? WIN_W'(1) : w;
    endfunction

endpackage

`default_nettype wire

[design/mctach_front.sv]
// ----------------------------------------------------------------------------
// mctach_front
// edge detection, saturating pulse counts and window tick counting
// ----------------------------------------------------------------------------
`default_nettype none

module mctach_front
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mctach_pkg::NUM_CH-1:0]     levels,
    input  wire logic                              ms_tick,
    input  wire logic [mctach_pkg::WIN_W-1:0]      window,
    input  wire mctach_pkg::q_stat_t               q_stat,
    output logic                                   push,
    output mctach_pkg::snap_t                      push_data
);
    import mctach_pkg::*;

    `include "multi_channel_tachometer_turbine_speed_unit_assert.svh"

    logic [NUM_CH-1:0] prev_reg;
    logic [NUM_CH-1:0] prev_next;
    snap_t             cnt_reg;
    snap_t             cnt_next;
    snap_t             cnt_inc;
    logic [WIN_W-1:0]  elapsed_reg;
    logic [WIN_W-1:0]  elapsed_next;
    logic [WIN_W-1:0]  elapsed_inc;
    logic [NUM_CH-1:0] rise;
    logic              accept;
    logic              close;

    assign in_ready = !q_stat.full;
    assign accept   = in_valid && in_ready;
    assign rise     = levels & ~prev_reg;

    always_comb
    begin
        cnt_inc = cnt_reg;
        for (int i = 0; i < NUM_CH; i++)
        begin
            if (rise[i] && (cnt_reg[i] < COUNT_LIMIT))
            begin
                cnt_inc[i] = cnt_reg[i] + 1'b1;
            end
        end
    end

    assign elapsed_inc = elapsed_reg + 1'b1;
    assign close       = ms_tick && (elapsed_inc >= eff_window(window));
    assign push        = accept && close;
    assign push_data   = cnt_inc;

    always_comb
    begin
        prev_next    = prev_reg;
        cnt_next     = cnt_reg;
        elapsed_next = elapsed_reg;
        if (accept)
        begin
            prev_next = levels;
            cnt_next  = cnt_inc;
            if (ms_tick)
            begin
                elapsed_next = elapsed_inc;
            end
            if (close)
            begin
                cnt_next     = '0;
                elapsed_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= '0;
            cnt_reg     <= '0;
            elapsed_reg <= '0;
        end
        else
        begin
            prev_reg    <= prev_next;
            cnt_reg     <= cnt_next;
            elapsed_reg <= elapsed_next;
        end
    end

    `MCT_ASSERT(a_no_push_when_full, !(push && q_stat.full))
    `MCT_ASSERT_NXT(a_counts_cleared, push, (cnt_reg == '0) && (elapsed_reg == '0))

endmodule

`default_nettype wire

[design/mctach_queue.sv]
// ----------------------------------------------------------------------------
// mctach_queue
// two entry queue of closed window counts between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module mctach_queue
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire mctach_pkg::snap_t    push_data,
    input  wire logic                 pop,
    output mctach_pkg::snap_t         pop_data,
    output mctach_pkg::q_stat_t       q_stat
);
    import mctach_pkg::*;

    `include "multi_channel_tachometer_turbine_speed_unit_assert.svh"

    snap_t       entry_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_data     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `MCT_ASSERT(a_count_bound, count_reg != 2'd3)

endmodule

`default_nettype wire

[design/mctach_back.sv]
// ----------------------------------------------------------------------------
// mctach_back
// rpm conversion with a shared serial divider, turbine blend, output register
// ----------------------------------------------------------------------------
`default_nettype none

module mctach_back
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mctach_pkg::cfg_t                    cfg,
    input  wire mctach_pkg::q_stat_t                 q_stat,
    input  wire mctach_pkg::snap_t                   pop_data,
    output logic                                     pop,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [mctach_pkg::OUT_DATA_W-1:0]        out_data
);
    import mctach_pkg::*;

    `include "multi_channel_tachometer_turbine_speed_unit_assert.svh"

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_BL_A = 7'b0001000,
        ST_BL_B = 7'b0010000,
        ST_BL_C = 7'b0100000,
        ST_EMIT = 7'b1000000
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [1:0]                    ch_reg;
    logic [1:0]                    ch_next;
    logic [4:0]                    step_reg;
    logic [4:0]                    step_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [SEQ_W-1:0]              seq_reg;
    logic [SEQ_W-1:0]              seq_next;

    snap_t                         snap_reg;
    logic [NUM_W-1:0]              num_reg;
    logic [DEN_W-1:0]              den_reg;
    logic [DEN_W-1:0]              rem_reg;
    logic [NUM_CH-1:0][RPM_W-1:0]  rpm_reg;
    logic [31:0]                   p1_reg;
    logic signed [33:0]            p2_reg;
    logic [RPM_W-1:0]              turbine_reg;
    logic [OUT_DATA_W-1:0]         out_data_reg;

    logic [TEETH_W-1:0]            teeth_sel;
    logic [TEETH_W-1:0]            teeth_eff;
    logic [CNT_W-1:0]              cnt_sel;
    logic [NUM_W-1:0]              num_prod;
    logic [DEN_W-1:0]              den_prod;
    logic [DEN_W:0]                div_sh;
    logic [DEN_W:0]                div_diff;
    logic                          div_ge;
    logic [RPM_W-1:0]              rpm_sat;
    logic signed [GAIN_W:0]        gain_m1;
    logic signed [GAIN_W:0]        n3_s;
    logic signed [34:0]            blend_t;
    logic [22:0]                   blend_q;
    logic [RPM_W-1:0]              blend_sat;
    logic                          last_step;
    logic                          load_out;

    // per channel divisor and dividend
    always_comb
    begin
        unique case (ch_reg)
            2'd0:    teeth_sel = cfg.teeth[CH_N2];
            2'd1:    teeth_sel = cfg.teeth[CH_N3];
            2'd2:    teeth_sel = cfg.teeth[CH_OUTPUT];
            2'd3:    teeth_sel = cfg.teeth[CH_ENGINE];
            default: teeth_sel = cfg.teeth[CH_N2];
        endcase
    end

    assign teeth_eff = (teeth_sel == '0) ? TEETH_W'(1) : teeth_sel;
    assign cnt_sel   = snap_reg[ch_reg];
    assign num_prod  = NUM_W'(cnt_sel) * NUM_W'(MS_PER_MIN);
    assign den_prod  = DEN_W'(teeth_eff) * DEN_W'(eff_window(cfg.window));

    // one restoring division step
    assign div_sh    = {rem_reg, num_reg[NUM_W-1]};
    assign div_diff  = div_sh - {1'b0, den_reg};
    assign div_ge    = (div_sh >= {1'b0, den_reg});
    assign last_step = (step_reg == 5'(NUM_W - 1));
    assign rpm_sat   = (num_reg[NUM_W-2:RPM_W-1] != '0) ? '1
                                                        : {num_reg[RPM_W-2:0], div_ge};

    // turbine blend
    assign gain_m1   = $signed({1'b0, cfg.gain}) - $signed(Q_ONE);
    assign n3_s      = $signed({1'b0, rpm_reg[CH_N3]});
    assign blend_t   = $signed({3'b000, p1_reg}) - 35'(p2_reg);
    assign blend_q   = blend_t[34:Q_FRAC];
    assign blend_sat = (blend_t <= 35'sd0)            ? '0 :
                       (blend_q[22:RPM_W] != '0)      ? '1 : blend_q[RPM_W-1:0];

    assign pop       = (state_reg == ST_IDLE) && !q_stat.empty;
    assign load_out  = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        step_next      = step_reg;
        seq_next       = seq_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    ch_next    = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    if (ch_reg == 2'(NUM_CH - 1))
                    begin
                        state_next = ST_BL_A;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_BL_A: state_next = ST_BL_B;
            ST_BL_B: state_next = ST_BL_C;
            ST_BL_C: state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    seq_next       = seq_reg + 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            step_reg      <= '0;
            seq_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            step_reg      <= step_next;
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            snap_reg <= pop_data;
        end
        if (state_reg == ST_MUL)
        begin
            num_reg <= num_prod;
            den_reg <= den_prod;
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            num_reg <= {num_reg[NUM_W-2:0], div_ge};
            rem_reg <= div_ge ? div_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
            if (last_step)
            begin
                rpm_reg[ch_reg] <= rpm_sat;
            end
        end
        if (state_reg == ST_BL_A)
        begin
            p1_reg <= 32'(rpm_reg[CH_N2]) * 32'(cfg.gain);
        end
        if (state_reg == ST_BL_B)
        begin
            p2_reg <= 34'(n3_s) * 34'(gain_m1);
        end
        if (state_reg == ST_BL_C)
        begin
            turbine_reg <= blend_sat;
        end
        if (load_out)
        begin
            out_data_reg <= {seq_reg + 1'b1, turbine_reg, rpm_reg[CH_ENGINE],
                             rpm_reg[CH_OUTPUT], rpm_reg[CH_N3], rpm_reg[CH_N2]};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MCT_ASSERT_NXT(a_seq_step, load_out, seq_reg == $past(seq_reg) + 16'd1)
    `MCT_ASSERT_NXT(a_emit_valid, load_out, out_valid_reg)

endmodule

`default_nettype wire

[design/multi_channel_tachometer_turbine_speed_unit.sv]
// ----------------------------------------------------------------------------
// multi_channel_tachometer_turbine_speed_unit
// four channel pulse count tachometer with turbine speed blend
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_axis    in         s_tvalid/s_tready   sensor levels and ms tick
//  m_axis    out        m_tvalid/m_tready   four rpm values, turbine rpm, seq
//  cfg       in         cfg_valid/cfg_ready register index and write data
//
//  the front takes one item per cycle while the window queue has room
//  per closed window the back pops the queue, runs the 31 step serial divider
//  once for each of the four channels, then does the turbine blend and the output load
//  s_tready drops only while two closed windows wait in the queue
//  async reset clears control state, configuration returns to its defaults
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_tachometer_turbine_speed_unit
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // level_n2, level_n3, level_output, level_engine, ms_tick, zero fill
    input  wire logic [mctach_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // n2_rpm, n3_rpm, shaft_speed, eng_speed, turb_speed, sample_seq
    output logic [mctach_pkg::OUT_DATA_W-1:0]        m_tdata,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [mctach_pkg::IDX_W-1:0]        cfg_index,
    input  wire logic [mctach_pkg::GAIN_W-1:0]       cfg_data
);
    import mctach_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    q_stat_t q_stat;
    logic    push;
    snap_t   push_data;
    logic    pop;
    snap_t   pop_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TEETH_N2:     cfg_next.teeth[CH_N2]     = cfg_data[TEETH_W-1:0];
                REG_TEETH_N3:     cfg_next.teeth[CH_N3]     = cfg_data[TEETH_W-1:0];
                REG_TEETH_OUTPUT: cfg_next.teeth[CH_OUTPUT] = cfg_data[TEETH_W-1:0];
                REG_ENGINE_PPR:   cfg_next.teeth[CH_ENGINE] = cfg_data[TEETH_W-1:0];
                REG_BLEND_GAIN:   cfg_next.gain             = cfg_data;
                REG_WINDOW_MS:    cfg_next.window           = cfg_data[WIN_W-1:0];
                default:          cfg_next                  = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.teeth[CH_N2]     <= 8'd60;
            cfg_reg.teeth[CH_N3]     <= 8'd60;
            cfg_reg.teeth[CH_OUTPUT] <= 8'd60;
            cfg_reg.teeth[CH_ENGINE] <= 8'd1;
            cfg_reg.gain             <= 16'd6722;
            cfg_reg.window           <= 10'd50;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mctach_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .levels    (s_tdata[NUM_CH-1:0]),
        .ms_tick   (s_tdata[NUM_CH]),
        .window    (cfg_reg.window),
        .q_stat    (q_stat),
        .push      (push),
        .push_data (push_data)
    );

    mctach_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_stat    (q_stat)
    );

    mctach_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

[sim/tb_multi_channel_tachometer_turbine_speed_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_channel_tachometer_turbine_speed_unit
// self-checking bench for the four channel tachometer: a directed table and
// randomized configuration phases drive sensor level items, a local speed
// model predicts each closed window that the table does not fix, and each output
// item is compared field by field against the oldest expected sample
// ----------------------------------------------------------------------------

module tb_multi_channel_tachometer_turbine_speed_unit;

    import mctach_pkg::*;

    localparam int TICK_BIT       = 4;
    localparam int BACK_CYCLES    = 200;
    localparam int HOLD_CYCLES    = 600;
    localparam int HOLD_AFTER     = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRESS_ITEMS    = 40;
    localparam int RANDOM_ITEMS   = 1500;
    localparam int DIR_ROWS       = 14;
    localparam int MAX_PRINTS     = 50;

    typedef struct packed {
        logic [7:0]            d;
        logic                  fixed;
        logic [OUT_DATA_W-1:0] want;
    } dir_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_W-1:0]      cfg_index;
    logic [GAIN_W-1:0]     cfg_data;

    // speed model state and configuration
    logic [3:0]         prev_levels_m;
    logic [CNT_W-1:0]   edge_count [NUM_CH];
    logic [WIN_W-1:0]   ticks_seen;
    logic [SEQ_W-1:0]   samples_sent;
    logic [TEETH_W-1:0] ppr_cfg [NUM_CH];
    logic [GAIN_W-1:0]  gain_cfg;
    logic [WIN_W-1:0]   window_cfg;

    logic [OUT_DATA_W-1:0] pending_speeds [$];
    dir_row_t              dir_rows [DIR_ROWS];
    int                    mismatches;
    int                    samples_checked;
    bit                    quiet_run;

    multi_channel_tachometer_turbine_speed_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [OUT_DATA_W-1:0] pack_speeds(input logic [15:0] n2,
                                                          input logic [15:0] n3,
                                                          input logic [15:0] o,
                                                          input logic [15:0] e,
                                                          input logic [15:0] t,
                                                          input logic [15:0] seq);
        pack_speeds = {seq, t, e, o, n3, n2};
    endfunction

    function automatic logic [15:0] rpm_of(input logic [CNT_W-1:0] cnt,
                                           input logic [TEETH_W-1:0] ppr,
                                           input logic [WIN_W-1:0] win);
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        num = cnt;
        num = num * MS_PER_MIN;
        den = (ppr == '0) ? 64'd1 : 64'(ppr);
        den = den * win;
        q = num / den;
        rpm_of = (q > 64'd65535) ? 16'hFFFF : q[15:0];
    endfunction

    function automatic logic [15:0] blend_turbine(input logic [15:0] n2,
                                                  input logic [15:0] n3,
                                                  input logic [GAIN_W-1:0] k_q);
        longint a;
        longint b;
        longint k;
        longint one;
        longint t;
        a = n2;
        b = n3;
        k = k_q;
        one = Q_ONE;
        t = a * k - b * (k - one);
        if (t <= 0)
        begin
            blend_turbine = 16'd0;
        end
        else
        begin
            t = t >>> Q_FRAC;
            blend_turbine = (t > 65535) ? 16'hFFFF : t[15:0];
        end
    endfunction

    // edge counting and window close for one accepted item
    task automatic advance_tach(input logic [7:0] d, output bit closed,
                                output logic [OUT_DATA_W-1:0] sample);
        logic [WIN_W-1:0] win;
        logic [15:0]      r [NUM_CH];
        closed = 1'b0;
        sample = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            if (d[ch] && !prev_levels_m[ch] && edge_count[ch] < COUNT_LIMIT)
                edge_count[ch] = edge_count[ch] + 1'b1;
        end
        prev_levels_m = d[3:0];
        if (d[TICK_BIT])
        begin
            win = (window_cfg == '0) ? WIN_W'(1) : window_cfg;
            ticks_seen = ticks_seen + 1'b1;
            if (ticks_seen >= win)
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                    r[ch] = rpm_of(edge_count[ch], ppr_cfg[ch], win);
                samples_sent = samples_sent + 1'b1;
                sample = pack_speeds(r[CH_N2], r[CH_N3], r[CH_OUTPUT], r[CH_ENGINE],
                                     blend_turbine(r[CH_N2], r[CH_N3], gain_cfg),
                                     samples_sent);
                closed = 1'b1;
                for (int ch = 0; ch < NUM_CH; ch++)
                    edge_count[ch] = '0;
                ticks_seen = '0;
            end
        end
    endtask

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic send_item(input logic [7:0] d, input logic fixed,
                             input logic [OUT_DATA_W-1:0] want);
        bit                    closed;
        logic [OUT_DATA_W-1:0] sample;
        while (!quiet_run && $urandom_range(0, 99) < 17)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_tach(d, closed, sample);
        if (closed)
            pending_speeds.push_back(fixed ? want : sample);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [GAIN_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_TEETH_N2:     ppr_cfg[CH_N2]     = v[TEETH_W-1:0];
            REG_TEETH_N3:     ppr_cfg[CH_N3]     = v[TEETH_W-1:0];
            REG_TEETH_OUTPUT: ppr_cfg[CH_OUTPUT] = v[TEETH_W-1:0];
            REG_ENGINE_PPR:   ppr_cfg[CH_ENGINE] = v[TEETH_W-1:0];
            REG_BLEND_GAIN:   gain_cfg           = v;
            REG_WINDOW_MS:    window_cfg         = v[WIN_W-1:0];
            default:          ;
        endcase
    endtask

    task automatic write_settings(input logic [7:0] tn2, input logic [7:0] tn3,
                                  input logic [7:0] tout, input logic [7:0] ppr,
                                  input logic [15:0] gain, input logic [9:0] win);
        write_reg(REG_TEETH_N2, {8'd0, tn2});
        write_reg(REG_TEETH_N3, {8'd0, tn3});
        write_reg(REG_TEETH_OUTPUT, {8'd0, tout});
        write_reg(REG_ENGINE_PPR, {8'd0, ppr});
        write_reg(REG_BLEND_GAIN, gain);
        write_reg(REG_WINDOW_MS, {6'd0, win});
        cfg_valid <= 1'b0;
    endtask

    // drain all predicted samples, then let the divider back end settle
    task automatic drain_speeds;
        s_tvalid <= 1'b0;
        while (pending_speeds.size() != 0)
            @(posedge clk);
        repeat (BACK_CYCLES) @(posedge clk);
    endtask

    task automatic check_sample(input logic [OUT_DATA_W-1:0] got);
        logic [OUT_DATA_W-1:0] want;
        string                 names [6];
        names = '{"n2_rpm", "n3_rpm", "shaft_speed", "eng_speed", "turb_speed",
                  "sample_seq"};
        if (pending_speeds.size() == 0)
        begin
            report_mismatch($sformatf("unexpected speed sample, sample_seq %0d",
                                      got[16*5 +: 16]));
        end
        else
        begin
            want = pending_speeds.pop_front();
            for (int f = 0; f < 6; f++)
            begin
                if (got[16*f +: 16] !== want[16*f +: 16])
                    report_mismatch($sformatf("%s got %0d want %0d", names[f],
                                              got[16*f +: 16], want[16*f +: 16]));
            end
        end
        samples_checked++;
    endtask

    // output side: random stalls plus one long hold-off
    initial
    begin : sink
        bit held;
        held = 1'b0;
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (!held && samples_checked >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= quiet_run || ($urandom_range(0, 99) >= 17);
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_sample(m_tdata);
        end
    end

    initial
    begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_multi_channel_tachometer_turbine_speed_unit: errors");
        $finish;
    end

    initial
    begin : stimulus
        int          phase;
        int          n_items;
        int          tick_pct;
        int          random_items;
        logic [7:0]  t_n2;
        logic [7:0]  t_n3;
        logic [7:0]  t_out;
        logic [7:0]  t_eng;
        logic [15:0] gain;
        logic [9:0]  win;

        mismatches      = 0;
        samples_checked = 0;
        quiet_run       = 1'b0;
        prev_levels_m   = '0;
        ticks_seen      = '0;
        samples_sent    = '0;
        for (int ch = 0; ch < NUM_CH; ch++)
            edge_count[ch] = '0;
        ppr_cfg[CH_N2]     = 8'd60;
        ppr_cfg[CH_N3]     = 8'd60;
        ppr_cfg[CH_OUTPUT] = 8'd60;
        ppr_cfg[CH_ENGINE] = 8'd1;
        gain_cfg           = 16'd6722;
        window_cfg         = 10'd50;

        // one tick windows on reset teeth and gain
        dir_rows = '{
            {8'h1F, 1'b1, pack_speeds(1000, 1000, 1000, 60000, 1000, 1)},
            {8'h1F, 1'b1, pack_speeds(0, 0, 0, 0, 0, 2)},
            {8'h00, 1'b0, 96'd0},
            {8'h1F, 1'b1, pack_speeds(1000, 1000, 1000, 60000, 1000, 3)},
            {8'h00, 1'b0, 96'd0},
            {8'h11, 1'b1, pack_speeds(1000, 0, 0, 0, 1641, 4)},
            {8'h00, 1'b0, 96'd0},
            {8'h12, 1'b1, pack_speeds(0, 1000, 0, 0, 0, 5)},
            {8'h04, 1'b0, 96'd0},
            {8'h00, 1'b0, 96'd0},
            {8'h14, 1'b1, pack_speeds(0, 0, 2000, 0, 0, 6)},
            {8'h08, 1'b0, 96'd0},
            {8'h00, 1'b0, 96'd0},
            {8'h18, 1'b1, pack_speeds(0, 0, 0, 65535, 0, 7)}
        };

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_TEETH_N2;
        cfg_data  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_WINDOW_MS, 16'd1);
        cfg_valid <= 1'b0;
        for (int i = 0; i < DIR_ROWS; i++)
            send_item(dir_rows[i].d, dir_rows[i].fixed, dir_rows[i].want);
        drain_speeds();

        // one tick windows back to back against a held receiver
        write_settings(8'd255, 8'd255, 8'd255, 8'd255, 16'd6722, 10'd1);
        quiet_run = 1'b1;
        for (int i = 0; i < PRESS_ITEMS; i++)
            send_item({3'b000, 1'b1, ((i % 2) == 0) ? 4'hF : 4'h0}, 1'b0, '0);
        quiet_run = 1'b0;
        drain_speeds();

        phase        = 0;
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case (phase)
                0: {t_n2, t_n3, t_out, t_eng, gain, win} =
                       {8'd60, 8'd60, 8'd60, 8'd1, 16'd6722, 10'd3};
                1: {t_n2, t_n3, t_out, t_eng, gain, win} =
                       {8'd1, 8'd1, 8'd1, 8'd1, 16'd65535, 10'd1};
                2: {t_n2, t_n3, t_out, t_eng, gain, win} =
                       {8'd255, 8'd255, 8'd255, 8'd255, 16'd4096, 10'd2};
                3: {t_n2, t_n3, t_out, t_eng, gain, win} =
                       {8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 10'd0};
                4: {t_n2, t_n3, t_out, t_eng, gain, win} =
                       {8'd60, 8'd60, 8'd60, 8'd1, 16'd6722, 10'd50};
                5: {t_n2, t_n3, t_out, t_eng, gain, win} =
                       {8'd60, 8'd60, 8'd60, 8'd1, 16'd1000, 10'd1};
                default:
                begin
                    t_n2  = 8'($urandom_range(0, 255));
                    t_n3  = 8'($urandom_range(0, 255));
                    t_out = 8'($urandom_range(0, 255));
                    t_eng = 8'($urandom_range(0, 255));
                    gain  = 16'($urandom_range(0, 65535));
                    win   = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(7, 40))
                                                        : 10'($urandom_range(1, 6));
                end
            endcase
            write_settings(t_n2, t_n3, t_out, t_eng, gain, win);
            quiet_run = (phase == 7);
            n_items  = (phase == 4) ? 60 : $urandom_range(40, 120);
            tick_pct = $urandom_range(10, 90);
            for (int j = 0; j < n_items; j++)
            begin
                send_item({3'b000, $urandom_range(0, 99) < tick_pct,
                           4'($urandom_range(0, 15))}, 1'b0, '0);
                random_items++;
            end
            quiet_run = 1'b0;
            drain_speeds();
            phase++;
        end

        if (mismatches == 0)
            $display("tb_multi_channel_tachometer_turbine_speed_unit: clean");
        else
            $display("tb_multi_channel_tachometer_turbine_speed_unit: errors");
        $finish;
    end

endmodule

[filelist.f]
+incdir+design
design/mctach_pkg.sv
design/mctach_front.sv
design/mctach_queue.sv
design/mctach_back.sv
design/multi_channel_tachometer_turbine_speed_unit.sv
sim/tb_multi_channel_tachometer_turbine_speed_unit.sv
